[rtl/core/ilis_pkg.sv]
package ilis_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned ActionW = 2;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IndexW  = 5;

  localparam logic [ActionW-1:0] ActInsert = 2'd0;
  localparam logic [ActionW-1:0] ActErase  = 2'd1;
  localparam logic [ActionW-1:0] ActSearch = 2'd2;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StRange = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  localparam logic [IndexW-1:0] NotFound = 5'h1f;

  typedef enum logic [2:0] {
    OpHold,
    OpInsert,
    OpErase,
    OpCompare,
    OpScan
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

[rtl/core/indexed_list_insert_erase_search_unit.sv]
// channel  signals                              direction
// in       in_valid_i in_ready_o action_i         input
//          position_i value_i
// out      out_valid_o out_ready_i status_o       output
//          found_index_o length_o
//
// insert and erase: the cells from the position on shift in the transfer cycle, the result is
//   registered at once, so one item per cycle while the output is taken
// search: first every cell compares its entry, then the match flags walk toward
//   cell 0, one cell per cycle, until cell 0 matches or the length is passed
// reset clears the entry count and control; list entries are unknown until written
// a stalled output holds the block: no transfer is taken until it drains
module indexed_list_insert_erase_search_unit import ilis_pkg::*; #(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ActionW-1:0]  action_i,
  input  logic [PosW-1:0]     position_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic signed [IndexW-1:0] found_index_o,
  output logic [IndexW-1:0]   length_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(Depth);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [IndexW-1:0] found_q, found_d;
  logic [IndexW-1:0] length_q, length_d;

  cell_ctrl_t        ctrl;
  logic [CmpW-1:0]   pos_ext, count_ext, scan_ext;
  logic              out_free, in_xfer;
  logic [ValueW-1:0] entry_w [Depth];
  logic              match_w [Depth];

  assign pos_ext   = CmpW'(position_i);
  assign count_ext = CmpW'(count_q);
  assign scan_ext  = CmpW'(scan_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_xfer   = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    found_d     = found_q;
    length_d    = length_q;
    ctrl.op     = OpHold;
    ctrl.value  = value_i;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          found_d  = NotFound;
          status_d = StDone;
          length_d = count_ext[IndexW-1:0];
          case (action_i)
            ActInsert: begin
              if (pos_ext > count_ext) begin
                status_d = StRange;
              end else if (count_ext == DepthC) begin
                status_d = StFull;
              end else begin
                ctrl.op  = OpInsert;
                count_d  = count_q + CntW'(1);
                length_d = IndexW'(count_d);
              end
            end
            ActErase: begin
              if (pos_ext >= count_ext) begin
                status_d = StRange;
              end else begin
                ctrl.op  = OpErase;
                count_d  = count_q - CntW'(1);
                length_d = IndexW'(count_d);
              end
            end
            ActSearch: begin
              ctrl.op = OpCompare;
              scan_d  = '0;
              state_d = StScan;
            end
            default: status_d = StRange;
          endcase
          out_valid_d = (action_i != ActSearch);
        end
      end
      StScan: begin
        if (scan_q >= count_q || match_w[0]) begin
          if (out_free) begin
            found_d     = match_w[0] && (scan_q < count_q) ?
                          scan_ext[IndexW-1:0] : NotFound;
            status_d    = StDone;
            length_d    = count_ext[IndexW-1:0];
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          ctrl.op = OpScan;
          scan_d  = scan_q + CntW'(1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    length_q <= length_d;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [ValueW-1:0] prev_entry, next_entry;
    logic              next_match;
    if (i == 0) begin : g_head
      assign prev_entry = value_i;
    end else begin : g_mid
      assign prev_entry = entry_w[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign next_entry = entry_w[i];
      assign next_match = 1'b0;
    end else begin : g_body
      assign next_entry = entry_w[i+1];
      assign next_match = match_w[i+1];
    end
    ilis_cell #(
      .Idx  (i),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .pos_i        (pos_ext),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .next_match_i (next_match),
      .entry_o      (entry_w[i]),
      .match_o      (match_w[i])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign length_o      = length_q;

endmodule

[rtl/core/ilis_cell.sv]
module ilis_cell import ilis_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CmpW = 5
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [CmpW-1:0]   pos_i,
  input  logic [ValueW-1:0] prev_entry_i,
  input  logic [ValueW-1:0] next_entry_i,
  input  logic              next_match_i,
  output logic [ValueW-1:0] entry_o,
  output logic              match_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              match_q, match_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    case (ctrl_i.op)
      OpInsert: begin
        if (MyIdx == pos_i) begin
          entry_d = ctrl_i.value;
        end else if (MyIdx > pos_i) begin
          entry_d = prev_entry_i;
        end
      end
      OpErase: begin
        if (MyIdx >= pos_i) begin
          entry_d = next_entry_i;
        end
      end
      OpCompare: match_d = (entry_q == ctrl_i.value);
      // match flags move one cell toward the head
      OpScan:    match_d = next_match_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule
